// ===== hw/rtl/isb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isb_pkg: shared types and constants of the image scaler
// Field widths, request function codes, register indexes, scale modes and
// the default size limits of the frame store.
// ----------------------------------------------------------------------------
package isb_pkg;

   // word field widths
   localparam int FUNC_W     = 1;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 8;

   // register widths
   localparam int SRC_DIM_W  = 9;
   localparam int DST_DIM_W  = 13;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // default limits
   localparam int DEF_MAX_SRC_WIDTH  = 256;
   localparam int DEF_MAX_SRC_HEIGHT = 256;
   localparam int DEF_MAX_DST_DIM    = 4096;
   localparam int DEF_FRAC_BITS      = 16;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_SCALE_MODE = 3'd4
   } csr_idx_type;

   // mode 3 falls through to truncated nearest
   localparam logic [MODE_W-1:0] MODE_BILINEAR      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEAREST_ROUND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEAREST_TRUNC = 2'd2;

   localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 9'd256;
   localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 9'd256;
   localparam logic [DST_DIM_W-1:0] DST_WIDTH_RST  = 13'd256;
   localparam logic [DST_DIM_W-1:0] DST_HEIGHT_RST = 13'd256;
   localparam logic [MODE_W-1:0]    SCALE_MODE_RST = MODE_BILINEAR;

endpackage : isb_pkg
`default_nettype wire

// ===== hw/rtl/isb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isb_req_if: request channel of the image scaler
// Valid/ready channel carrying pixel writes and output pixel reads.
// ----------------------------------------------------------------------------
interface isb_req_if;
   import isb_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [PIX_W-1:0]   pixel_in;

   modport source (output valid, output func, output col, output row,
                   output pixel_in, input ready);
   modport sink   (input valid, input func, input col, input row,
                   input pixel_in, output ready);
endinterface : isb_req_if
`default_nettype wire

// ===== hw/rtl/isb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isb_rsp_if: response channel of the image scaler
// Valid/ready channel carrying one scaled pixel per read request.
// ----------------------------------------------------------------------------
interface isb_rsp_if;
   import isb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface : isb_rsp_if
`default_nettype wire

// ===== hw/rtl/image_scaler_bilinear_nearest.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_scaler_bilinear_nearest: 8-bit grayscale frame scaler
// Holds a source frame in four parity banks and returns bilinear or
// nearest-neighbor output pixels at requested destination coordinates.
// ----------------------------------------------------------------------------
//  channel   direction  word contents                      handshake
//  req_if    in         func, col, row, pixel_in            valid/ready
//  rsp_if    out        pixel_out (one per read)            valid/ready
//  csr_*     in         csr_idx, csr_wdata                  csr_we strobe
//
//  One word per cycle while req_if.ready is high; a read result passes the
//  address path, a bank read and the horizontal and vertical blend in turn.
//  After reset and after each write to a defined register the step divider
//  runs, one quotient bit a cycle,
//  with req_if.ready low. The frame store is not cleared.
//  Up to eight reads may be in flight or waiting in the response queue;
//  ready drops while eight are outstanding.
// ----------------------------------------------------------------------------
module image_scaler_bilinear_nearest #(
   parameter int MAX_SRC_WIDTH  = isb_pkg::DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = isb_pkg::DEF_MAX_SRC_HEIGHT,
   parameter int MAX_DST_DIM    = isb_pkg::DEF_MAX_DST_DIM,
   parameter int FRAC_BITS      = isb_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   isb_req_if.sink                          req_if,
   isb_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [isb_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [isb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import isb_pkg::*;

   localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int SDW   = (SWW > SHW) ? SWW : SHW;
   localparam int DW    = $clog2(MAX_DST_DIM + 1);
   localparam int NW    = SDW + FRAC_BITS + 1;
   localparam int CNTW  = $clog2(NW + 1);
   localparam int PW    = COORD_W + NW;
   localparam int IPW   = PW - FRAC_BITS;
   localparam int SIW   = $clog2(MAX_SRC_WIDTH);
   localparam int SRW   = $clog2(MAX_SRC_HEIGHT);
   localparam int CB    = (SIW > 1) ? SIW - 1 : 1;
   localparam int RB    = (SRW > 1) ? SRW - 1 : 1;
   localparam int BAW   = CB + RB;
   localparam int BDEPTH = 1 << BAW;
   localparam int FIFO_DEPTH = 8;
   localparam int FPW   = $clog2(FIFO_DEPTH);
   localparam int OCW   = FPW + 1;

   // (a*(1-f) + b*f) >> FRAC_BITS, written as a + (b-a)*f
   function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] f);
      logic signed [PIX_W:0]             diff;
      logic signed [PIX_W+FRAC_BITS+1:0] acc;
      diff = signed'({1'b0, b}) - signed'({1'b0, a});
      acc  = signed'({2'b00, a, {FRAC_BITS{1'b0}}}) + diff * signed'({1'b0, f});
      return acc[PIX_W+FRAC_BITS-1:FRAC_BITS];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [SRC_DIM_W-1:0] src_width_ff, src_height_ff;
   logic [DST_DIM_W-1:0] dst_width_ff, dst_height_ff;
   logic [MODE_W-1:0]    scale_mode_ff;
   logic                 csr_hit;

   assign csr_hit = csr_we && (csr_idx <= CSR_SCALE_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
         dst_width_ff  <= DST_WIDTH_RST;
         dst_height_ff <= DST_HEIGHT_RST;
         scale_mode_ff <= SCALE_MODE_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SRC_DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SRC_DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[DST_DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[DST_DIM_W-1:0];
            CSR_SCALE_MODE: scale_mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated sizes: zero counts as one, large values clip to the limit
   logic [SWW-1:0] sw_sat;
   logic [SHW-1:0] sh_sat;
   logic [DW-1:0]  dw_sat, dh_sat;

   always_comb begin
      if (src_width_ff == '0)                        sw_sat = SWW'(1);
      else if (32'(src_width_ff) > MAX_SRC_WIDTH)    sw_sat = SWW'(MAX_SRC_WIDTH);
      else                                           sw_sat = SWW'(src_width_ff);
      if (src_height_ff == '0)                       sh_sat = SHW'(1);
      else if (32'(src_height_ff) > MAX_SRC_HEIGHT)  sh_sat = SHW'(MAX_SRC_HEIGHT);
      else                                           sh_sat = SHW'(src_height_ff);
      if (dst_width_ff == '0)                        dw_sat = DW'(1);
      else if (32'(dst_width_ff) > MAX_DST_DIM)      dw_sat = DW'(MAX_DST_DIM);
      else                                           dw_sat = DW'(dst_width_ff);
      if (dst_height_ff == '0)                       dh_sat = DW'(1);
      else if (32'(dst_height_ff) > MAX_DST_DIM)     dh_sat = DW'(MAX_DST_DIM);
      else                                           dh_sat = DW'(dst_height_ff);
   end

   logic copy_mode, bil_mode, round_mode;

   assign copy_mode  = (32'(sw_sat) == 32'(dw_sat)) && (32'(sh_sat) == 32'(dh_sat));
   assign bil_mode   = (scale_mode_ff == MODE_BILINEAR) && !copy_mode;
   assign round_mode = (scale_mode_ff == MODE_NEAREST_ROUND);

   // ------------------------------------------------------------ step divider
   logic            start_ff;
   logic [CNTW-1:0] div_cnt_ff;
   logic [NW-1:0]   num_c_ff, num_r_ff, num_c_in, num_r_in;
   logic [NW-1:0]   load_c, load_r;
   logic [DW-1:0]   rem_c_ff, rem_r_ff, rem_c_in, rem_r_in;
   logic [DW:0]     trial_c, trial_r;
   logic            ge_c, ge_r;
   logic [NW-1:0]   col_step_ff, row_step_ff;
   logic [NW-1:0]   half_q;

   assign half_q = round_mode ? (NW'(1) << (FRAC_BITS - 1)) : '0;
   assign load_c = (NW'(sw_sat) << FRAC_BITS) + half_q;
   assign load_r = (NW'(sh_sat) << FRAC_BITS) + half_q;

   always_comb begin
      trial_c  = {rem_c_ff, num_c_ff[NW-1]};
      trial_r  = {rem_r_ff, num_r_ff[NW-1]};
      ge_c     = trial_c >= {1'b0, dw_sat};
      ge_r     = trial_r >= {1'b0, dh_sat};
      rem_c_in = ge_c ? DW'(trial_c - {1'b0, dw_sat}) : trial_c[DW-1:0];
      rem_r_in = ge_r ? DW'(trial_r - {1'b0, dh_sat}) : trial_r[DW-1:0];
      num_c_in = {num_c_ff[NW-2:0], ge_c};
      num_r_in = {num_r_ff[NW-2:0], ge_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= 1'b1;
         div_cnt_ff <= '0;
      end else begin
         start_ff <= csr_hit;
         if (start_ff) begin
            div_cnt_ff <= CNTW'(NW);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         num_c_ff <= load_c;
         num_r_ff <= load_r;
         rem_c_ff <= '0;
         rem_r_ff <= '0;
      end else if (div_cnt_ff != '0) begin
         num_c_ff <= num_c_in;
         num_r_ff <= num_r_in;
         rem_c_ff <= rem_c_in;
         rem_r_ff <= rem_r_in;
         if (div_cnt_ff == CNTW'(1)) begin
            col_step_ff <= num_c_in;
            row_step_ff <= num_r_in;
         end
      end
   end

   // --------------------------------------------------------------- handshake
   logic [OCW-1:0] out_cnt_ff;
   logic           req_fire, read_fire, rsp_fire;

   assign req_if.ready = !start_ff && (div_cnt_ff == '0) && (out_cnt_ff != OCW'(FIFO_DEPTH));
   assign req_fire     = req_if.valid && req_if.ready;
   assign read_fire    = req_fire && (req_if.func == FUNC_READ);

   // ------------------------------------------------- stage 1: clamp to dest
   logic               v1_ff, rd1_ff;
   logic [COORD_W-1:0] col1_ff, row1_ff, col1_in, row1_in;
   logic [PIX_W-1:0]   pix1_ff;

   always_comb begin
      col1_in = req_if.col;
      row1_in = req_if.row;
      if (req_if.func == FUNC_READ) begin
         if (32'(req_if.col) >= 32'(dw_sat)) col1_in = COORD_W'(dw_sat - 1'b1);
         if (32'(req_if.row) >= 32'(dh_sat)) row1_in = COORD_W'(dh_sat - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= req_fire;
      rd1_ff  <= (req_if.func == FUNC_READ);
      col1_ff <= col1_in;
      row1_ff <= row1_in;
      pix1_ff <= req_if.pixel_in;
   end

   // ---------------------------------------------- stage 2: scaled position
   logic               v2_ff, rd2_ff;
   logic [COORD_W-1:0] col2_ff, row2_ff;
   logic [PIX_W-1:0]   pix2_ff;
   logic [PW-1:0]      px2_ff, py2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      rd2_ff  <= rd1_ff;
      col2_ff <= col1_ff;
      row2_ff <= row1_ff;
      pix2_ff <= pix1_ff;
      px2_ff  <= PW'(col1_ff) * PW'(col_step_ff);
      py2_ff  <= PW'(row1_ff) * PW'(row_step_ff);
   end

   // --------------------------------------- stage 3: base index and weights
   logic [IPW-1:0]       ipx, ipy;
   logic [SIW-1:0]       x0_in, xcl;
   logic [SRW-1:0]       y0_in, ycl;
   logic                 xinc_in, yinc_in, we_in;
   logic [FRAC_BITS-1:0] fx_in, fy_in;

   always_comb begin
      ipx = px2_ff[PW-1:FRAC_BITS];
      ipy = py2_ff[PW-1:FRAC_BITS];
      xcl = (ipx >= IPW'(sw_sat)) ? SIW'(sw_sat - 1'b1) : SIW'(ipx);
      ycl = (ipy >= IPW'(sh_sat)) ? SRW'(sh_sat - 1'b1) : SRW'(ipy);
      // writes and copies address the frame directly
      x0_in   = (!rd2_ff || copy_mode) ? SIW'(col2_ff) : xcl;
      y0_in   = (!rd2_ff || copy_mode) ? SRW'(row2_ff) : ycl;
      xinc_in = rd2_ff && bil_mode && ((32'(x0_in) + 32'd1) != 32'(sw_sat));
      yinc_in = rd2_ff && bil_mode && ((32'(y0_in) + 32'd1) != 32'(sh_sat));
      fx_in   = (rd2_ff && bil_mode) ? px2_ff[FRAC_BITS-1:0] : '0;
      fy_in   = (rd2_ff && bil_mode) ? py2_ff[FRAC_BITS-1:0] : '0;
      we_in   = v2_ff && !rd2_ff && (32'(col2_ff) < 32'(sw_sat))
                && (32'(row2_ff) < 32'(sh_sat));
   end

   logic                 rv3_ff, we3_ff, xinc3_ff, yinc3_ff;
   logic [SIW-1:0]       x03_ff;
   logic [SRW-1:0]       y03_ff;
   logic [FRAC_BITS-1:0] fx3_ff, fy3_ff;
   logic [PIX_W-1:0]     pix3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv3_ff <= 1'b0;
         we3_ff <= 1'b0;
      end else begin
         rv3_ff <= v2_ff && rd2_ff;
         we3_ff <= we_in;
      end
      x03_ff   <= x0_in;
      y03_ff   <= y0_in;
      xinc3_ff <= xinc_in;
      yinc3_ff <= yinc_in;
      fx3_ff   <= fx_in;
      fy3_ff   <= fy_in;
      pix3_ff  <= pix2_ff;
   end

   // ------------------------------------------ frame store: four parity banks
   logic [SIW-1:0]   x13;
   logic [SRW-1:0]   y13;
   logic [CB-1:0]    caddr [2];
   logic [RB-1:0]    raddr [2];
   logic [BAW-1:0]   bank_addr [4];
   logic             bank_we [4];
   logic [PIX_W-1:0] bank_q_ff [4];

   assign x13 = x03_ff + SIW'(xinc3_ff);
   assign y13 = y03_ff + SRW'(yinc3_ff);

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         // each parity bank sees whichever of the two neighbors has its parity
         caddr[p] = (x03_ff[0] == p[0]) ? CB'(x03_ff >> 1) : CB'(x13 >> 1);
         raddr[p] = (y03_ff[0] == p[0]) ? RB'(y03_ff >> 1) : RB'(y13 >> 1);
      end
      for (int g = 0; g < 4; g++) begin
         bank_addr[g] = {raddr[g / 2], caddr[g % 2]};
         bank_we[g]   = we3_ff && (x03_ff[0] == g[0]) && (y03_ff[0] == g[1]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [PIX_W-1:0] bank_mem [BDEPTH];

      always_ff @(posedge clock) begin
         if (bank_we[g]) bank_mem[bank_addr[g]] <= pix3_ff;
         bank_q_ff[g] <= bank_mem[bank_addr[g]];
      end
   end

   // ------------------------------------------- stage 4: horizontal blend
   logic                 rv4_ff, px0_4_ff, px1_4_ff, py0_4_ff, py1_4_ff;
   logic [FRAC_BITS-1:0] fx4_ff, fy4_ff;

   always_ff @(posedge clock) begin
      if (reset) rv4_ff <= 1'b0;
      else       rv4_ff <= rv3_ff;
      px0_4_ff <= x03_ff[0];
      px1_4_ff <= x13[0];
      py0_4_ff <= y03_ff[0];
      py1_4_ff <= y13[0];
      fx4_ff   <= fx3_ff;
      fy4_ff   <= fy3_ff;
   end

   logic [PIX_W-1:0] a00, a10, a01, a11;

   assign a00 = bank_q_ff[{py0_4_ff, px0_4_ff}];
   assign a10 = bank_q_ff[{py0_4_ff, px1_4_ff}];
   assign a01 = bank_q_ff[{py1_4_ff, px0_4_ff}];
   assign a11 = bank_q_ff[{py1_4_ff, px1_4_ff}];

   logic                 rv5_ff;
   logic [PIX_W-1:0]     top5_ff, bot5_ff;
   logic [FRAC_BITS-1:0] fy5_ff;

   always_ff @(posedge clock) begin
      if (reset) rv5_ff <= 1'b0;
      else       rv5_ff <= rv4_ff;
      top5_ff <= blend(a00, a10, fx4_ff);
      bot5_ff <= blend(a01, a11, fx4_ff);
      fy5_ff  <= fy4_ff;
   end

   // ------------------------------------ stage 5: vertical blend into queue
   logic [PIX_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [FPW:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FPW:0]     fifo_fill;

   assign fifo_fill        = wr_ptr_ff - rd_ptr_ff;
   assign rsp_if.valid     = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_if.pixel_out = fifo_mem[rd_ptr_ff[FPW-1:0]];
   assign rsp_fire         = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (rv5_ff) fifo_mem[wr_ptr_ff[FPW-1:0]] <= blend(top5_ff, bot5_ff, fy5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (rv5_ff)   wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_fire) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         // count reads accepted but not yet delivered
         out_cnt_ff <= out_cnt_ff + OCW'(read_fire) - OCW'(rsp_fire);
      end
   end

   // -------------------------------------------------------------- checks
   a_fill_le_outstanding: assert property (@(posedge clock) disable iff (reset)
      fifo_fill <= out_cnt_ff)
      else $error("response queue holds more words than reads outstanding");

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      rv5_ff |-> (fifo_fill != (FPW+1)'(FIFO_DEPTH)) || rsp_fire)
      else $error("response queue written while full");

   a_cfg_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> !req_if.ready)
      else $error("request taken before steps were recomputed");

   a_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      rv5_ff |-> (out_cnt_ff != '0))
      else $error("blend result without an outstanding read");

endmodule : image_scaler_bilinear_nearest
`default_nettype wire

// ===== tb/tb_image_scaler_bilinear_nearest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_scaler_bilinear_nearest: self-checking bench for the frame scaler
// Loads small source frames, switches sizes and scale modes between phases
// and checks every output pixel against a bit-accurate scaling predictor.
// The sender runs in random bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_image_scaler_bilinear_nearest;
   import isb_pkg::*;

   localparam int FRAME_W        = DEF_MAX_SRC_WIDTH;
   localparam int FRAME_WORDS    = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int WORD_TARGET    = 1700;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;
   localparam longint unsigned ONE_Q = 64'd1 << DEF_FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;
   localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIX_W-1:0]   pix;
   } scaler_word_t;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   isb_req_if req_bus ();
   isb_rsp_if rsp_bus ();

   image_scaler_bilinear_nearest dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // predictor state: register copy, steps and the stored source frame
   logic [SRC_DIM_W-1:0] reg_src_w, reg_src_h;
   logic [DST_DIM_W-1:0] reg_dst_w, reg_dst_h;
   logic [MODE_W-1:0]    reg_mode;
   longint unsigned      col_step, row_step;
   logic [PIX_W-1:0]     frame_pixels [0:FRAME_WORDS-1];
   bit                   pixel_loaded [0:FRAME_WORDS-1];

   scaler_word_t     pending_words [$];
   logic [PIX_W-1:0] expected_pixels [$];

   int words_planned;
   int mismatch_count;
   int results_seen;
   int burst_left, gap_left;
   int hold_left, stall_mode, pattern_age;
   int quiet_cycles;

   always #6 clock = ~clock;

   function automatic int unsigned sat_dim(input int unsigned v, input int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function automatic int unsigned src_cols();
      return sat_dim(reg_src_w, DEF_MAX_SRC_WIDTH);
   endfunction

   function automatic int unsigned src_rows();
      return sat_dim(reg_src_h, DEF_MAX_SRC_HEIGHT);
   endfunction

   function automatic int unsigned dst_cols();
      return sat_dim(reg_dst_w, DEF_MAX_DST_DIM);
   endfunction

   function automatic int unsigned dst_rows();
      return sat_dim(reg_dst_h, DEF_MAX_DST_DIM);
   endfunction

   function automatic longint unsigned q_step(input int unsigned old_size,
                                              input int unsigned new_size,
                                              input bit rounded);
      longint unsigned num;
      num = old_size;
      num = num << DEF_FRAC_BITS;
      if (rounded) num = num + ONE_Q / 2;
      return num / new_size;
   endfunction

   function automatic void update_steps();
      col_step = q_step(src_cols(), dst_cols(), reg_mode == MODE_NEAREST_ROUND);
      row_step = q_step(src_rows(), dst_rows(), reg_mode == MODE_NEAREST_ROUND);
   endfunction

   function automatic int unsigned clamp_index(input longint unsigned v,
                                               input int unsigned size);
      int unsigned idx;
      idx = (v >= size) ? size - 1 : v;
      return idx;
   endfunction

   function automatic int unsigned blend(input longint unsigned a, input longint unsigned b,
                                         input longint unsigned f);
      longint unsigned acc;
      acc = a * (ONE_Q - f) + b * f;
      return acc >> DEF_FRAC_BITS;
   endfunction

   function automatic longint unsigned src_pixel(input int unsigned c, input int unsigned r);
      return frame_pixels[r * FRAME_W + c];
   endfunction

   function automatic logic [PIX_W-1:0] scaled_pixel(input int unsigned col_in,
                                                     input int unsigned row_in);
      int unsigned sw, sh, dw, dh, c, r, x0, y0, x1, y1, top, bot;
      longint unsigned pos_x, pos_y;
      sw = src_cols();
      sh = src_rows();
      dw = dst_cols();
      dh = dst_rows();
      c = (col_in >= dw) ? dw - 1 : col_in;
      r = (row_in >= dh) ? dh - 1 : row_in;
      if (sw == dw && sh == dh) return frame_pixels[r * FRAME_W + c];
      pos_x = c;
      pos_x = pos_x * col_step;
      pos_y = r;
      pos_y = pos_y * row_step;
      x0 = clamp_index(pos_x >> DEF_FRAC_BITS, sw);
      y0 = clamp_index(pos_y >> DEF_FRAC_BITS, sh);
      if (reg_mode != MODE_BILINEAR) return frame_pixels[y0 * FRAME_W + x0];
      // no right or lower neighbor on the last column or row
      x1 = (x0 == sw - 1) ? x0 : x0 + 1;
      y1 = (y0 == sh - 1) ? y0 : y0 + 1;
      top = blend(src_pixel(x0, y0), src_pixel(x1, y0), pos_x & (ONE_Q - 1));
      bot = blend(src_pixel(x0, y1), src_pixel(x1, y1), pos_x & (ONE_Q - 1));
      return blend(top, bot, pos_y & (ONE_Q - 1));
   endfunction

   function automatic void apply_word(input logic [FUNC_W-1:0] func,
                                      input int unsigned col, input int unsigned row,
                                      input logic [PIX_W-1:0] pix);
      if (func == FUNC_WRITE) begin
         if (col < src_cols() && row < src_rows()) frame_pixels[row * FRAME_W + col] = pix;
      end else begin
         expected_pixels.push_back(scaled_pixel(col, row));
      end
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      scaler_word_t next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_word(req_bus.func, req_bus.col, req_bus.row, req_bus.pixel_in);
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.func     <= next_word.func;
               req_bus.col      <= next_word.col;
               req_bus.row      <= next_word.row;
               req_bus.pixel_in <= next_word.pix;
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                           : $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left   = 0;
         stall_mode  = 0;
         pattern_age = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen = results_seen + 1;
            if (expected_pixels.size() == 0) begin
               $display("%0t ns: pixel_out %0d with no read outstanding", $time,
                        rsp_bus.pixel_out);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.pixel_out !== want) begin
                  $display("%0t ns: pixel_out expected %0d, got %0d", $time, want,
                           rsp_bus.pixel_out);
                  mismatch_count = mismatch_count + 1;
               end
            end
            // back up the block until it stalls its input
            if (results_seen == 200 || results_seen == 900) hold_left = LONG_HOLD;
         end
         pattern_age = pattern_age + 1;
         if (pattern_age == 50) begin
            pattern_age = 0;
            stall_mode  = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= $urandom_range(0, 1);
               2:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_image_scaler_bilinear_nearest failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic settle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
      // trailing pixel writes may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
      do @(negedge clock);
      while (req_bus.ready !== 1'b1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_SRC_WIDTH:  reg_src_w = value[SRC_DIM_W-1:0];
         CSR_SRC_HEIGHT: reg_src_h = value[SRC_DIM_W-1:0];
         CSR_DST_WIDTH:  reg_dst_w = value[DST_DIM_W-1:0];
         CSR_DST_HEIGHT: reg_dst_h = value[DST_DIM_W-1:0];
         CSR_SCALE_MODE: reg_mode  = value[MODE_W-1:0];
         default: ;
      endcase
      update_steps();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_geometry(input int unsigned sw, input int unsigned sh,
                                 input int unsigned dw, input int unsigned dh,
                                 input int unsigned mode);
      settle();
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      write_reg(CSR_SCALE_MODE, mode);
      @(negedge clock);
   endtask

   task automatic queue_write(input int unsigned c, input int unsigned r,
                              input int unsigned p);
      scaler_word_t w;
      w.func = FUNC_WRITE;
      w.col  = c;
      w.row  = r;
      w.pix  = p;
      if (c < src_cols() && r < src_rows()) pixel_loaded[r * FRAME_W + c] = 1'b1;
      pending_words.push_back(w);
      words_planned = words_planned + 1;
   endtask

   task automatic queue_read(input int unsigned c, input int unsigned r);
      scaler_word_t w;
      w.func = FUNC_READ;
      w.col  = c;
      w.row  = r;
      w.pix  = $urandom_range(0, 255);
      pending_words.push_back(w);
      words_planned = words_planned + 1;
   endtask

   // every pixel a read can touch must be written first
   task automatic load_region();
      for (int r = 0; r < src_rows(); r++)
         for (int c = 0; c < src_cols(); c++)
            if (!pixel_loaded[r * FRAME_W + c]) queue_write(c, r, $urandom_range(0, 255));
   endtask

   initial begin
      int unsigned sw, sh, scols, srows, dw, dh, mode, pick, n_words, c, r;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_idx        = CSR_SRC_WIDTH;
      csr_wdata      = '0;
      req_bus.valid    = 1'b0;
      req_bus.func     = FUNC_WRITE;
      req_bus.col      = '0;
      req_bus.row      = '0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      reg_src_w      = SRC_WIDTH_RST;
      reg_src_h      = SRC_HEIGHT_RST;
      reg_dst_w      = DST_WIDTH_RST;
      reg_dst_h      = DST_HEIGHT_RST;
      reg_mode       = SCALE_MODE_RST;
      update_steps();
      words_planned  = 0;
      mismatch_count = 0;
      results_seen   = 0;
      quiet_cycles   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: plain copy, pixel extremes, ignored writes, saturated reads
      apply_geometry(2, 2, 2, 2, MODE_BILINEAR);
      queue_write(0, 0, 8'h00);
      queue_write(1, 0, 8'hFF);
      queue_write(0, 1, 8'hA5);
      queue_write(1, 1, 8'h5A);
      queue_write(2, 0, 8'h11);
      queue_write(COORD_MAX, COORD_MAX, 8'hFF);
      queue_read(0, 0);
      queue_read(1, 0);
      queue_read(1, 1);
      queue_read(COORD_MAX, COORD_MAX);
      // bilinear upscale, last column and row have no neighbor
      apply_geometry(2, 2, 7, 5, MODE_BILINEAR);
      queue_read(3, 2);
      queue_read(6, 4);
      queue_read(0, COORD_MAX);
      // rounded step overruns the source on a large upscale
      apply_geometry(2, 2, DEF_MAX_DST_DIM, DEF_MAX_DST_DIM, MODE_NEAREST_ROUND);
      queue_read(COORD_MAX, COORD_MAX);
      queue_read(COORD_MAX, 0);
      // spare mode, zero destination height
      apply_geometry(2, 2, 1, 0, MODE_SPARE);
      queue_read(0, 0);
      queue_read(100, 7);
      // zero source width, oversized destination width
      apply_geometry(0, 2, (1 << CSR_DATA_W) - 1, 2, MODE_NEAREST_TRUNC);
      queue_read(COORD_MAX, 1);
      queue_read(0, 0);
      apply_geometry(2, 2, 1, 1, MODE_BILINEAR);
      write_reg(CSR_IDX_UNUSED, (1 << CSR_DATA_W) - 1);
      @(negedge clock);
      queue_read(0, 0);

      // random phases
      for (int phase = 0; words_planned < WORD_TARGET; phase++) begin
         sw = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 20);
         sh = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 20);
         case (phase)
            1: begin sw = DEF_MAX_SRC_WIDTH; sh = 1; end
            3: begin sw = 1; sh = DEF_MAX_SRC_HEIGHT; end
            5: begin sw = 300; sh = 0; end
            default: ;
         endcase
         scols = sat_dim(sw, DEF_MAX_SRC_WIDTH);
         srows = sat_dim(sh, DEF_MAX_SRC_HEIGHT);
         case ($urandom_range(0, 5))
            0: begin dw = scols; dh = srows; end
            1: begin dw = $urandom_range(1, scols); dh = $urandom_range(1, srows); end
            2: begin
               dw = $urandom_range(scols, (scols * 8 > 4096) ? 4096 : scols * 8);
               dh = $urandom_range(srows, (srows * 8 > 4096) ? 4096 : srows * 8);
            end
            3: begin dw = $urandom_range(1, 64); dh = $urandom_range(1, 64); end
            4: begin dw = $urandom_range(2048, 4096); dh = $urandom_range(2048, 4096); end
            default: begin
               dw = $urandom_range(0, 1) ? 0 : $urandom_range(4097, (1 << CSR_DATA_W) - 1);
               dh = $urandom_range(0, 1) ? 0 : $urandom_range(4097, (1 << CSR_DATA_W) - 1);
            end
         endcase
         mode = $urandom_range(0, 3);
         apply_geometry(sw, sh, dw, dh, mode);
         load_region();
         n_words = $urandom_range(40, 140);
         for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               pick = $urandom_range(0, 19);
               if (pick < 17) begin
                  c = $urandom_range(0, dst_cols() - 1);
                  r = $urandom_range(0, dst_rows() - 1);
               end else if (pick < 19) begin
                  c = $urandom_range(0, COORD_MAX);
                  r = $urandom_range(0, COORD_MAX);
               end else begin
                  c = COORD_MAX;
                  r = dst_rows() - 1;
               end
               queue_read(c, r);
            end else if (pick < 90) begin
               queue_write($urandom_range(0, src_cols() - 1), $urandom_range(0, src_rows() - 1),
                           $urandom_range(0, 255));
            end else if ($urandom_range(0, 1)) begin
               // off the source frame: drop
               queue_write($urandom_range(src_cols(), COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, 255));
            end else begin
               queue_write($urandom_range(0, COORD_MAX), $urandom_range(src_rows(), COORD_MAX),
                           $urandom_range(0, 255));
            end
         end
      end

      settle();
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("tb_image_scaler_bilinear_nearest passed");
      end else begin
         $display("tb_image_scaler_bilinear_nearest failed");
      end
      $finish;
   end

endmodule : tb_image_scaler_bilinear_nearest

// ===== files.f =====
hw/rtl/isb_pkg.sv
hw/rtl/isb_req_if.sv
hw/rtl/isb_rsp_if.sv
hw/rtl/image_scaler_bilinear_nearest.sv
tb/tb_image_scaler_bilinear_nearest.sv
